### src/sqt_pkg.sv
// ----------------------------------------------------------------------------
// sqt_pkg
// Shared widths, item types and the sine table generator for the rotated
// sprite quad pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sqt_pkg;

  // field widths
  localparam int unsigned POS_W    = 24;  // Q16.8 signed positions
  localparam int unsigned SIZE_W   = 23;  // Q15.8 unsigned sizes
  localparam int unsigned FRAC_W   = 17;  // Q1.16 fractions
  localparam int unsigned TEX_W    = 18;  // Q2.16 texture sums
  localparam int unsigned ANGLE_W  = 16;  // binary angle
  localparam int unsigned HANDLE_W = 32;  // texture handle

  // internal widths
  localparam int unsigned QUAD_W   = 24;  // rounded quad width and height
  localparam int unsigned PIV_W    = 25;  // rounded pivot offset
  localparam int unsigned OFF_W    = 26;  // signed corner offset
  localparam int unsigned SINE_W   = 17;  // sine magnitude, up to 65536
  localparam int unsigned TRIG_W   = 18;  // signed sine and cosine
  localparam int unsigned ANGLE_FRAC_W = 14;  // angle bits inside a quadrant
  localparam int unsigned ROUND_SHIFT  = 16;
  localparam int unsigned ROUND_HALF   = 32768;

  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  // sine table generation, Q30 fixed point
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SINE_ROUND  = 64'd8192;
  localparam longint unsigned SINE_CAP    = 64'd65536;
  localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42,
                                                 64'd72, 64'd110, 64'd156};

  typedef enum logic [1:0] {
    CORNER_BL = 2'd0,
    CORNER_TL = 2'd1,
    CORNER_TR = 2'd2,
    CORNER_BR = 2'd3
  } corner_t;

  // one sprite request as taken from the input channel
  typedef struct packed {
    logic signed [POS_W-1:0] dst_x;
    logic signed [POS_W-1:0] dst_y;
    logic [SIZE_W-1:0]       dst_w;
    logic [SIZE_W-1:0]       dst_h;
    logic [FRAC_W-1:0]       uv_x;
    logic [FRAC_W-1:0]       uv_y;
    logic [FRAC_W-1:0]       uv_w;
    logic [FRAC_W-1:0]       uv_h;
    logic [FRAC_W-1:0]       pivot_x;
    logic [FRAC_W-1:0]       pivot_y;
    logic [ANGLE_W-1:0]      angle;
    logic [HANDLE_W-1:0]     texture_id;
  } sqt_req_t;

  // sprite after setup: offsets, trig values and texture corners
  typedef struct packed {
    logic signed [OFF_W-1:0]  ox_l;
    logic signed [OFF_W-1:0]  ox_r;
    logic signed [OFF_W-1:0]  oy_t;
    logic signed [OFF_W-1:0]  oy_b;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [POS_W-1:0]  dst_x;
    logic signed [POS_W-1:0]  dst_y;
    logic [TEX_W-1:0]         u1;
    logic [TEX_W-1:0]         u2;
    logic [TEX_W-1:0]         v1;
    logic [TEX_W-1:0]         v2;
    logic [HANDLE_W-1:0]      texture;
  } sqt_item_t;

  // one corner on its way through the rotation stages
  typedef struct packed {
    corner_t                  corner;
    logic                     last;
    logic signed [OFF_W-1:0]  ox;
    logic signed [OFF_W-1:0]  oy;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [POS_W-1:0]  dst_x;
    logic signed [POS_W-1:0]  dst_y;
    logic [TEX_W-1:0]         u;
    logic [TEX_W-1:0]         v;
    logic [HANDLE_W-1:0]      texture;
  } sqt_corner_t;

  // finished vertex
  typedef struct packed {
    corner_t                 corner;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [HANDLE_W-1:0]     texture;
    logic                    last;
  } sqt_vertex_t;

  // Quarter-wave sine entry for table position t (Q30 fraction of a quarter
  // turn). Evaluated at elaboration only.
  function automatic logic [SINE_W-1:0] sine_entry(input longint unsigned t);
    longint unsigned x;
    longint unsigned mag;
    longint unsigned r;
    longint          sum;
    x   = (t * HALF_PI_Q30) >> 30;
    mag = x;
    sum = longint'(x);
    for (int n = 0; n < 6; n++) begin
      mag = (mag * x) >> 30;
      mag = (mag * x) >> 30;
      mag = mag / TAYLOR_DIV[n];
      if (n % 2 == 0) begin
        sum = sum - longint'(mag);
      end else begin
        sum = sum + longint'(mag);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(unsigned'(sum)) + SINE_ROUND) >> 14;
    if (r > SINE_CAP) begin
      r = SINE_CAP;
    end
    return r[SINE_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/sprite_quad_transform.sv
// ----------------------------------------------------------------------------
// sprite_quad_transform
// Turns one sprite request into its four rotated, translated corner vertices
// with texture coordinates.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   sprite request, one per item
//  out_     output     out_valid/out_stall one corner vertex per item
//
//  A sprite yields four corners, issued one a cycle while the corner stages do
//  not stall, so the corner sequencer, not setup, sets the sustained rate.
//  The first corner passes the setup, sequencer and rotation registers in turn.
//  Synchronous active-low reset clears all valid bits; no table fill needed.
//  out_stall freezes the corner stages; in_stall rises once all three setup
//  stages hold work and the sequencer cannot take the next sprite.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_quad_transform #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [sqt_pkg::POS_W-1:0]     in_dst_x,
  input  wire logic signed [sqt_pkg::POS_W-1:0]     in_dst_y,
  input  wire logic [sqt_pkg::SIZE_W-1:0]           in_dst_w,
  input  wire logic [sqt_pkg::SIZE_W-1:0]           in_dst_h,
  input  wire logic [sqt_pkg::FRAC_W-1:0]           in_uv_x,
  input  wire logic [sqt_pkg::FRAC_W-1:0]           in_uv_y,
  input  wire logic [sqt_pkg::FRAC_W-1:0]           in_uv_w,
  input  wire logic [sqt_pkg::FRAC_W-1:0]           in_uv_h,
  input  wire logic [sqt_pkg::FRAC_W-1:0]           in_pivot_x,
  input  wire logic [sqt_pkg::FRAC_W-1:0]           in_pivot_y,
  input  wire logic [sqt_pkg::ANGLE_W-1:0]          in_angle,
  input  wire logic [sqt_pkg::HANDLE_W-1:0]         in_texture_id,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [1:0]                                out_corner,
  output logic signed [sqt_pkg::POS_W-1:0]          out_pos_x,
  output logic signed [sqt_pkg::POS_W-1:0]          out_pos_y,
  output logic [sqt_pkg::TEX_W-1:0]                 out_tex_u,
  output logic [sqt_pkg::TEX_W-1:0]                 out_tex_v,
  output logic [sqt_pkg::HANDLE_W-1:0]              out_texture_out,
  output logic                                      out_last_corner
);

  import sqt_pkg::*;

  sqt_req_t    req;
  sqt_item_t   item;
  sqt_corner_t corner;
  sqt_vertex_t vtx;
  logic        item_valid, item_stall;
  logic        corner_valid, corner_stall;

  always_comb begin
    req.dst_x      = in_dst_x;
    req.dst_y      = in_dst_y;
    req.dst_w      = in_dst_w;
    req.dst_h      = in_dst_h;
    req.uv_x       = in_uv_x;
    req.uv_y       = in_uv_y;
    req.uv_w       = in_uv_w;
    req.uv_h       = in_uv_h;
    req.pivot_x    = in_pivot_x;
    req.pivot_y    = in_pivot_y;
    req.angle      = in_angle;
    req.texture_id = in_texture_id;
  end

  sqt_setup #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_setup (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_stall  (in_stall),
    .req        (req),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item)
  );

  sqt_corner_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .corner_valid (corner_valid),
    .corner_stall (corner_stall),
    .corner       (corner)
  );

  sqt_rotate u_rotate (
    .clk          (clk),
    .rst_n        (rst_n),
    .corner_valid (corner_valid),
    .corner_stall (corner_stall),
    .corner       (corner),
    .vtx_valid    (out_valid),
    .vtx_stall    (out_stall),
    .vtx          (vtx)
  );

  assign out_corner      = vtx.corner;
  assign out_pos_x       = vtx.pos_x;
  assign out_pos_y       = vtx.pos_y;
  assign out_tex_u       = vtx.tex_u;
  assign out_tex_v       = vtx.tex_v;
  assign out_texture_out = vtx.texture;
  assign out_last_corner = vtx.last;

`ifndef SYNTH
  a_last_on_br : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_corner == (out_corner == CORNER_BR)))
    else $error("last_corner flag does not match corner");

  a_corner_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=>
      !out_valid || (out_corner == 2'($past(out_corner) + 2'd1)))
    else $error("corners out of order");

  a_handle_kept : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_corner |=>
      !out_valid || (out_texture_out == $past(out_texture_out)))
    else $error("texture handle changed within a sprite");
`endif

endmodule

`default_nettype wire

### src/sqt_setup.sv
// ----------------------------------------------------------------------------
// sqt_setup
// Three-stage per-sprite setup: quad size, pivot offsets, sine and cosine
// lookup and texture corners. Takes one sprite per cycle when not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sqt_setup #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire sqt_pkg::sqt_req_t req,
  output logic                  item_valid,
  input  wire logic             item_stall,
  output sqt_pkg::sqt_item_t    item
);

  import sqt_pkg::*;

  localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned IPROD_W = IDX_W + ANGLE_FRAC_W + 1;
  localparam int unsigned QPROD_W = SIZE_W + FRAC_W;
  localparam int unsigned CPROD_W = QUAD_W + FRAC_W;

  typedef struct packed {
    logic signed [POS_W-1:0] dst_x;
    logic signed [POS_W-1:0] dst_y;
    logic [TEX_W-1:0]        u1;
    logic [TEX_W-1:0]        u2;
    logic [TEX_W-1:0]        v1;
    logic [TEX_W-1:0]        v2;
    logic [HANDLE_W-1:0]     texture;
  } pass_t;

  // constant sine table, quarter wave, entries 0..depth
  logic [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam longint unsigned T = (64'(k) << 30) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = sine_entry(T);
  end

  // stage valids and hold chain
  logic v1_r, v2_r, v3_r;
  logic hold1, hold2, hold3;

  assign hold3     = v3_r && item_stall;
  assign hold2     = v2_r && hold3;
  assign hold1     = v1_r && hold2;
  assign req_stall = hold1;

  // ---------------- stage 1: quad size, table index ----------------
  logic [QPROD_W-1:0] qw_prod, qh_prod;
  logic [IPROD_W-1:0] idx_prod;
  logic [IDX_W:0]     idx_raw;
  logic [IDX_W-1:0]   base_idx;
  pass_t              pass1_nxt;

  logic [QUAD_W-1:0]  qw1_r, qh1_r;
  logic [IDX_W-1:0]   base_idx1_r;
  logic [1:0]         quad1_r;
  logic [FRAC_W-1:0]  pvx1_r, pvy1_r;
  pass_t              pass1_r;

  always_comb begin
    qw_prod  = QPROD_W'(req.dst_w) * QPROD_W'(req.uv_w) + QPROD_W'(ROUND_HALF);
    qh_prod  = QPROD_W'(req.dst_h) * QPROD_W'(req.uv_h) + QPROD_W'(ROUND_HALF);
    idx_prod = IPROD_W'(req.angle[ANGLE_FRAC_W-1:0]) * IPROD_W'(SINE_TABLE_DEPTH)
             + (IPROD_W'(1) << (ANGLE_FRAC_W - 1));
    idx_raw  = idx_prod[IPROD_W-1:ANGLE_FRAC_W];
    if (idx_raw > (IDX_W+1)'(SINE_TABLE_DEPTH)) begin
      base_idx = IDX_W'(SINE_TABLE_DEPTH);
    end else begin
      base_idx = idx_raw[IDX_W-1:0];
    end
    pass1_nxt.dst_x   = req.dst_x;
    pass1_nxt.dst_y   = req.dst_y;
    pass1_nxt.u1      = TEX_W'(req.uv_x);
    pass1_nxt.u2      = TEX_W'(req.uv_x) + TEX_W'(req.uv_w);
    pass1_nxt.v1      = TEX_W'(req.uv_y);
    pass1_nxt.v2      = TEX_W'(req.uv_y) + TEX_W'(req.uv_h);
    pass1_nxt.texture = req.texture_id;
  end

  always_ff @(posedge clk) begin
    if (!hold1) begin
      qw1_r       <= qw_prod[QPROD_W-1:ROUND_SHIFT];
      qh1_r       <= qh_prod[QPROD_W-1:ROUND_SHIFT];
      base_idx1_r <= base_idx;
      quad1_r     <= req.angle[ANGLE_W-1:ANGLE_FRAC_W];
      pvx1_r      <= req.pivot_x;
      pvy1_r      <= req.pivot_y;
      pass1_r     <= pass1_nxt;
    end
  end

  // ---------------- stage 2: pivot offsets, table read ----------------
  logic [CPROD_W-1:0] cx_prod, cy_prod;
  logic [IDX_W-1:0]   mirror_idx, sin_idx, cos_idx;

  logic [PIV_W-1:0]   cx2_r, cy2_r;
  logic [QUAD_W-1:0]  qw2_r, qh2_r;
  logic [SINE_W-1:0]  sin_mag2_r, cos_mag2_r;
  logic               sin_neg2_r, cos_neg2_r;
  pass_t              pass2_r;

  always_comb begin
    cx_prod    = CPROD_W'(qw1_r) * CPROD_W'(pvx1_r) + CPROD_W'(ROUND_HALF);
    cy_prod    = CPROD_W'(qh1_r) * CPROD_W'(pvy1_r) + CPROD_W'(ROUND_HALF);
    mirror_idx = IDX_W'(SINE_TABLE_DEPTH) - base_idx1_r;
    // odd quadrants run the quarter wave backwards; cosine is one quadrant on
    sin_idx    = quad1_r[0] ? mirror_idx : base_idx1_r;
    cos_idx    = quad1_r[0] ? base_idx1_r : mirror_idx;
  end

  always_ff @(posedge clk) begin
    if (!hold2) begin
      cx2_r      <= cx_prod[CPROD_W-1:ROUND_SHIFT];
      cy2_r      <= cy_prod[CPROD_W-1:ROUND_SHIFT];
      qw2_r      <= qw1_r;
      qh2_r      <= qh1_r;
      sin_mag2_r <= sine_rom[sin_idx];
      cos_mag2_r <= sine_rom[cos_idx];
      sin_neg2_r <= quad1_r[1];
      cos_neg2_r <= quad1_r[1] ^ quad1_r[0];
      pass2_r    <= pass1_r;
    end
  end

  // ---------------- stage 3: signed offsets and trig ----------------
  sqt_item_t item_nxt;
  sqt_item_t item_r;

  always_comb begin
    item_nxt.ox_l    = -OFF_W'(signed'({1'b0, cx2_r}));
    item_nxt.ox_r    = OFF_W'(signed'({1'b0, qw2_r})) - OFF_W'(signed'({1'b0, cx2_r}));
    item_nxt.oy_t    = -OFF_W'(signed'({1'b0, cy2_r}));
    item_nxt.oy_b    = OFF_W'(signed'({1'b0, qh2_r})) - OFF_W'(signed'({1'b0, cy2_r}));
    item_nxt.sin_v   = sin_neg2_r ? -TRIG_W'(sin_mag2_r) : TRIG_W'(sin_mag2_r);
    item_nxt.cos_v   = cos_neg2_r ? -TRIG_W'(cos_mag2_r) : TRIG_W'(cos_mag2_r);
    item_nxt.dst_x   = pass2_r.dst_x;
    item_nxt.dst_y   = pass2_r.dst_y;
    item_nxt.u1      = pass2_r.u1;
    item_nxt.u2      = pass2_r.u2;
    item_nxt.v1      = pass2_r.v1;
    item_nxt.v2      = pass2_r.v2;
    item_nxt.texture = pass2_r.texture;
  end

  always_ff @(posedge clk) begin
    if (!hold3) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (!hold1) v1_r <= req_valid;
      if (!hold2) v2_r <= v1_r;
      if (!hold3) v3_r <= v2_r;
    end
  end

  assign item_valid = v3_r;
  assign item       = item_r;

endmodule

`default_nettype wire

### src/sqt_corner_seq.sv
// ----------------------------------------------------------------------------
// sqt_corner_seq
// Holds one set-up sprite and issues its four corners, one per cycle while
// corner_stall is low, in the order bottom-left, top-left, top-right, bottom-right.
// ----------------------------------------------------------------------------
`default_nettype none

module sqt_corner_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire sqt_pkg::sqt_item_t item,
  output logic                    corner_valid,
  input  wire logic               corner_stall,
  output sqt_pkg::sqt_corner_t    corner
);

  import sqt_pkg::*;

  sqt_item_t hold_r;
  logic      hold_v_r;
  corner_t   cnt_r;
  logic      issue;
  logic      done;
  logic      take;

  assign issue      = hold_v_r && !corner_stall;
  assign done       = issue && (cnt_r == CORNER_BR);
  assign item_stall = hold_v_r && !done;
  assign take       = item_valid && !item_stall;

  always_comb begin
    corner.corner  = cnt_r;
    corner.last    = (cnt_r == CORNER_BR);
    corner.sin_v   = hold_r.sin_v;
    corner.cos_v   = hold_r.cos_v;
    corner.dst_x   = hold_r.dst_x;
    corner.dst_y   = hold_r.dst_y;
    corner.texture = hold_r.texture;
    unique case (cnt_r)
      CORNER_BL: begin
        corner.ox = hold_r.ox_l;
        corner.oy = hold_r.oy_b;
        corner.u  = hold_r.u1;
        corner.v  = hold_r.v2;
      end
      CORNER_TL: begin
        corner.ox = hold_r.ox_l;
        corner.oy = hold_r.oy_t;
        corner.u  = hold_r.u1;
        corner.v  = hold_r.v1;
      end
      CORNER_TR: begin
        corner.ox = hold_r.ox_r;
        corner.oy = hold_r.oy_t;
        corner.u  = hold_r.u2;
        corner.v  = hold_r.v1;
      end
      CORNER_BR: begin
        corner.ox = hold_r.ox_r;
        corner.oy = hold_r.oy_b;
        corner.u  = hold_r.u2;
        corner.v  = hold_r.v2;
      end
      default: begin
        corner.ox = hold_r.ox_l;
        corner.oy = hold_r.oy_b;
        corner.u  = hold_r.u1;
        corner.v  = hold_r.v2;
      end
    endcase
  end

  assign corner_valid = hold_v_r;

  always_ff @(posedge clk) begin
    if (take) begin
      hold_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      cnt_r    <= CORNER_BL;
    end else if (take) begin
      hold_v_r <= 1'b1;
      cnt_r    <= CORNER_BL;
    end else if (issue) begin
      // drop the sprite after its last corner
      if (done) hold_v_r <= 1'b0;
      cnt_r <= corner_t'(cnt_r + 2'd1);
    end
  end

endmodule

`default_nettype wire

### src/sqt_rotate.sv
// ----------------------------------------------------------------------------
// sqt_rotate
// Three-stage corner pipeline: rotation products, rounding, translation with
// saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sqt_rotate (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 corner_valid,
  output logic                      corner_stall,
  input  wire sqt_pkg::sqt_corner_t corner,
  output logic                      vtx_valid,
  input  wire logic                 vtx_stall,
  output sqt_pkg::sqt_vertex_t      vtx
);

  import sqt_pkg::*;

  localparam int unsigned MUL_W = TRIG_W + OFF_W;
  localparam int unsigned SUM_W = MUL_W + 1;
  localparam int unsigned RND_W = SUM_W - ROUND_SHIFT;
  localparam int unsigned ADD_W = RND_W + 1;

  typedef struct packed {
    corner_t                 corner;
    logic                    last;
    logic signed [POS_W-1:0] dst_x;
    logic signed [POS_W-1:0] dst_y;
    logic [TEX_W-1:0]        u;
    logic [TEX_W-1:0]        v;
    logic [HANDLE_W-1:0]     texture;
  } pass_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ADD_W-1:0] x);
    logic signed [POS_W-1:0] r;
    if (x > ADD_W'(POS_MAX)) begin
      r = POS_MAX;
    end else if (x < ADD_W'(POS_MIN)) begin
      r = POS_MIN;
    end else begin
      r = x[POS_W-1:0];
    end
    return r;
  endfunction

  logic v1_r, v2_r, v3_r;
  logic hold1, hold2, hold3;

  assign hold3        = v3_r && vtx_stall;
  assign hold2        = v2_r && hold3;
  assign hold1        = v1_r && hold2;
  assign corner_stall = hold1;

  // ---------------- stage 1: products ----------------
  logic signed [MUL_W-1:0] cos_ox1_r, sin_oy1_r, sin_ox1_r, cos_oy1_r;
  pass_t                   pass1_r;

  always_ff @(posedge clk) begin
    if (!hold1) begin
      cos_ox1_r       <= MUL_W'(corner.cos_v) * MUL_W'(corner.ox);
      sin_oy1_r       <= MUL_W'(corner.sin_v) * MUL_W'(corner.oy);
      sin_ox1_r       <= MUL_W'(corner.sin_v) * MUL_W'(corner.ox);
      cos_oy1_r       <= MUL_W'(corner.cos_v) * MUL_W'(corner.oy);
      pass1_r.corner  <= corner.corner;
      pass1_r.last    <= corner.last;
      pass1_r.dst_x   <= corner.dst_x;
      pass1_r.dst_y   <= corner.dst_y;
      pass1_r.u       <= corner.u;
      pass1_r.v       <= corner.v;
      pass1_r.texture <= corner.texture;
    end
  end

  // ---------------- stage 2: combine and round ----------------
  logic signed [SUM_W-1:0] rx_sum, ry_sum;
  logic signed [RND_W-1:0] rx2_r, ry2_r;
  pass_t                   pass2_r;

  always_comb begin
    rx_sum = SUM_W'(cos_ox1_r) - SUM_W'(sin_oy1_r) + SUM_W'(ROUND_HALF);
    ry_sum = SUM_W'(sin_ox1_r) + SUM_W'(cos_oy1_r) + SUM_W'(ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    if (!hold2) begin
      rx2_r   <= rx_sum[SUM_W-1:ROUND_SHIFT];
      ry2_r   <= ry_sum[SUM_W-1:ROUND_SHIFT];
      pass2_r <= pass1_r;
    end
  end

  // ---------------- stage 3: translate, saturate, output ----------------
  logic signed [ADD_W-1:0] px_sum, py_sum;
  sqt_vertex_t             vtx_nxt;
  sqt_vertex_t             vtx_r;

  always_comb begin
    px_sum          = ADD_W'(rx2_r) + ADD_W'(pass2_r.dst_x);
    py_sum          = ADD_W'(ry2_r) + ADD_W'(pass2_r.dst_y);
    vtx_nxt.corner  = pass2_r.corner;
    vtx_nxt.pos_x   = sat_pos(px_sum);
    vtx_nxt.pos_y   = sat_pos(py_sum);
    vtx_nxt.tex_u   = pass2_r.u;
    vtx_nxt.tex_v   = pass2_r.v;
    vtx_nxt.texture = pass2_r.texture;
    vtx_nxt.last    = pass2_r.last;
  end

  always_ff @(posedge clk) begin
    if (!hold3) begin
      vtx_r <= vtx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (!hold1) v1_r <= corner_valid;
      if (!hold2) v2_r <= v1_r;
      if (!hold3) v3_r <= v2_r;
    end
  end

  assign vtx_valid = v3_r;
  assign vtx       = vtx_r;

endmodule

`default_nettype wire
